### design/re_pkg.sv
// Shared types and constants for the range encoder.
package re_pkg;

  localparam int CUM_W           = 16;
  localparam int CFG_W           = 48;
  localparam int BYTE_W          = 8;
  localparam int STATE_BYTES_DEF = 6;
  localparam int PRECISION_DEF   = 16;

  localparam logic [BYTE_W-1:0] BYTE_ONES     = 8'hff;
  localparam logic [CFG_W-1:0]  MIN_WIDTH_RST = 48'd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_HI,
    S_MUL_LO,
    S_ADD_LO,
    S_CHECK,
    S_EMIT,
    S_FLUSH_INC,
    S_FLUSH_EMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_ADD_LO,
    OP_CHECK,
    OP_EMIT,
    OP_FLUSH_INC,
    OP_FLUSH_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_action;  // action bit of the offered input transaction
    logic emit_more;  // top bytes of both bounds agree and bytes remain
    logic last_byte;  // byte count is at its final position
    logic out_free;   // output register can take a byte this cycle
  } dp_status_t;

endpackage

### design/re_ctrl.sv
// Controller state machine that sequences the range encoder datapath.
module re_ctrl
  import re_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = status.in_action ? S_FLUSH_INC : S_MUL_HI;
        end
      end
      S_MUL_HI: begin
        cmd.op     = OP_MUL_HI;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.op     = OP_MUL_LO;
        state_next = S_ADD_LO;
      end
      S_ADD_LO: begin
        cmd.op     = OP_ADD_LO;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.op     = OP_CHECK;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!status.emit_more) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.op = OP_EMIT;
        end
      end
      S_FLUSH_INC: begin
        cmd.op     = OP_FLUSH_INC;
        state_next = S_FLUSH_EMIT;
      end
      S_FLUSH_EMIT: begin
        if (status.out_free) begin
          cmd.op = OP_FLUSH_EMIT;
          if (status.last_byte) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/re_datapath.sv
// Datapath of the range encoder: bounds, shared multiplier, byte shifter and output register.
module re_datapath
  import re_pkg::*;
#(
  parameter int STATE_BYTES = STATE_BYTES_DEF,
  parameter int PRECISION   = PRECISION_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic [2*CUM_W-1:0]  s_tdata,
  input  logic                s_tuser,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [BYTE_W-1:0]   m_tdata,
  output logic                m_tlast
);

  localparam int W      = BYTE_W * STATE_BYTES;
  localparam int PROD_W = W + CUM_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CNT_W  = $clog2(STATE_BYTES + 1);

  localparam logic [W-1:0]     BOUND_ONES = '1;
  localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(STATE_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(STATE_BYTES - 1);

  logic [CFG_W-1:0]  min_width;
  logic [W-1:0]      bound_low, bound_high;
  logic [W-1:0]      range_q;
  logic [CUM_W-1:0]  cum_low, cum_high;
  logic [PROD_W-1:0] prod;
  logic [W-1:0]      new_low, new_high;
  logic [CNT_W-1:0]  cnt;

  logic [CUM_W-1:0]  mul_op;
  logic [PROD_W-1:0] mul_res;
  logic [SUM_W-1:0]  sum;
  logic [W-1:0]      sum_sat;
  logic [W-1:0]      diff;
  logic              collapse;
  logic              out_free;
  logic              top_equal;
  logic              next_differs;

  // One multiplier serves both cumulative bounds on consecutive cycles.
  assign mul_op  = (cmd.op == OP_MUL_LO) ? cum_low : cum_high;
  assign mul_res = (PROD_W'(range_q) * PROD_W'(mul_op)) >> PRECISION;

  // The low bound gets one more than the high bound; the carry-in follows the command.
  assign sum     = SUM_W'(bound_low) + SUM_W'(prod) + SUM_W'(cmd.op == OP_ADD_LO);
  assign sum_sat = (|sum[SUM_W-1:W]) ? BOUND_ONES : sum[W-1:0];

  assign diff     = new_high - new_low;
  assign collapse = (new_low > new_high) || (CFG_W'(diff) < min_width);

  assign out_free     = !m_tvalid || m_tready;
  assign top_equal    = bound_low[W-1 -: BYTE_W] == bound_high[W-1 -: BYTE_W];
  assign next_differs = bound_low[W-BYTE_W-1 -: BYTE_W] != bound_high[W-BYTE_W-1 -: BYTE_W];

  assign status.in_action = s_tuser;
  assign status.emit_more = (cnt != CNT_FULL) && top_equal;
  assign status.last_byte = (cnt == CNT_LAST);
  assign status.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= MIN_WIDTH_RST;
    end else if (cfg_wen) begin
      min_width <= cfg_wdata;
    end
  end

  // Working registers; they carry no meaning between items.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        range_q  <= bound_high - bound_low;
        cum_low  <= s_tdata[CUM_W-1:0];
        cum_high <= s_tdata[2*CUM_W-1:CUM_W];
      end
      OP_MUL_HI: begin
        prod <= mul_res;
      end
      OP_MUL_LO: begin
        new_high <= sum_sat;
        prod     <= mul_res;
      end
      OP_ADD_LO: begin
        new_low <= sum_sat;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_low  <= '0;
      bound_high <= BOUND_ONES;
      cnt        <= '0;
    end else begin
      unique case (cmd.op)
        OP_CHECK: begin
          bound_low  <= new_low;
          bound_high <= collapse ? new_low : new_high;
          cnt        <= '0;
        end
        OP_EMIT: begin
          bound_low  <= {bound_low[W-BYTE_W-1:0], {BYTE_W{1'b0}}};
          bound_high <= {bound_high[W-BYTE_W-1:0], BYTE_ONES};
          cnt        <= cnt + CNT_W'(1);
        end
        OP_FLUSH_INC: begin
          bound_low <= bound_low + W'(1);
          cnt       <= '0;
        end
        OP_FLUSH_EMIT: begin
          if (status.last_byte) begin
            bound_low  <= '0;
            bound_high <= BOUND_ONES;
            cnt        <= '0;
          end else begin
            bound_low <= {bound_low[W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            cnt       <= cnt + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_EMIT || cmd.op == OP_FLUSH_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      m_tdata <= bound_low[W-1 -: BYTE_W];
      m_tlast <= status.last_byte || next_differs;
    end else if (cmd.op == OP_FLUSH_EMIT) begin
      m_tdata <= bound_low[W-1 -: BYTE_W];
      m_tlast <= status.last_byte;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_FULL)
    else $error("byte count beyond the bound width");

  a_check_order: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_CHECK |=> bound_low <= bound_high)
    else $error("interval inverted after narrowing");

  a_flush_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FLUSH_EMIT && status.last_byte) |=>
      (bound_low == '0 && bound_high == BOUND_ONES))
    else $error("bounds not restored after flush");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(cmd.op) == OP_EMIT || $past(cmd.op) == OP_FLUSH_EMIT))
    else $error("output became valid without an emit command");

endmodule

### design/range_encoder_core.sv
// Top level of the byte-oriented range encoder.
//
// Input channel (s_*): one transaction per symbol. s_tuser is the action bit
// (0 encode, 1 flush); s_tdata carries the symbol's cumulative bounds at
// PRECISION bits. s_tready is high only while the coder waits for work.
// Output channel (m_*): one compressed byte per transaction, m_tlast on the
// final byte that an input transaction produces. An encode may produce none.
// Configuration: cfg_wen writes cfg_wdata into the collapse threshold; write
// it only while the coder is idle.
// An encode steps from acceptance through MUL_HI, MUL_LO, ADD_LO and CHECK
// to EMIT, which sends n bytes (0 to STATE_BYTES); MUL_HI, MUL_LO and ADD_LO
// belong to the shared multiplier and the bound adder, which handle the upper
// and lower cumulative bound one after the other. A flush steps through
// FLUSH_INC and FLUSH_EMIT and emits STATE_BYTES bytes.
// A stalled receiver holds the byte in the output register and freezes the
// byte sequencer until it is taken. Synchronous reset clears the bounds to
// the full interval and the threshold to 65536; flush restores only the bounds.
module range_encoder_core
  import re_pkg::*;
#(
  parameter int STATE_BYTES = STATE_BYTES_DEF,
  parameter int PRECISION   = PRECISION_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [2*CUM_W-1:0]  s_tdata,   // [15:0] cum_low, [31:16] cum_high
  input  logic                s_tuser,   // [0] action
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [BYTE_W-1:0]   m_tdata,   // [7:0] out_byte
  output logic                m_tlast
);

  dp_cmd_t    cmd;
  dp_status_t status;

  re_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  re_datapath #(
    .STATE_BYTES (STATE_BYTES),
    .PRECISION   (PRECISION)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
